FILE: rtl/assert_macros.svh
// Assertion macros used by frame_chunk_reassembly_ring.
// Each macro is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FCRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FCRR_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define FCRR_ASSERT(label, prop, msg)
`define FCRR_ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: rtl/fcrr_pkg.sv
// ----------------------------------------------------------------------------
// fcrr_pkg
// Types and constants of the frame chunk reassembly ring.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrr_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned FNUM_W  = 32;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned CLEN_W  = 16;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned CNT_W   = HOLD_W + 1;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 8'd8;

  localparam logic [PADDR_W-3:0] REG_CORRUPT_HOLDOFF = '0;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] rcv;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             clear_all;
    logic             invalidate;
    logic [IDX_W-1:0] inval_addr;
  } wr_req_t;

endpackage

`default_nettype wire

FILE: rtl/fcrr_slot_store.sv
// ----------------------------------------------------------------------------
// fcrr_slot_store
// Slot memory with two registered read ports, one write port and a valid
// bit per slot; an invalid slot reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrr_slot_store (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          re_i,
  input  wire  [fcrr_pkg::IDX_W-1:0]   raddr_a_i,
  input  wire  [fcrr_pkg::IDX_W-1:0]   raddr_b_i,
  input  wire  fcrr_pkg::wr_req_t      wr_i,
  output fcrr_pkg::slot_t              rdata_a_o,
  output fcrr_pkg::slot_t              rdata_b_o
);

  fcrr_pkg::slot_t                 mem [fcrr_pkg::SLOTS];
  fcrr_pkg::slot_t                 rdata_a_q;
  fcrr_pkg::slot_t                 rdata_b_q;
  logic [fcrr_pkg::IDX_W-1:0]      raddr_a_q;
  logic [fcrr_pkg::IDX_W-1:0]      raddr_b_q;
  logic [fcrr_pkg::SLOTS-1:0]      valid_q;
  logic [fcrr_pkg::SLOTS-1:0]      valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr] <= wr_i.wdata;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
      raddr_a_q <= raddr_a_i;
      raddr_b_q <= raddr_b_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_i.clear_all) begin
      valid_d = '0;
    end
    if (wr_i.invalidate) begin
      valid_d[wr_i.inval_addr] = 1'b0;
    end
    if (wr_i.we) begin
      valid_d[wr_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rdata_a_o = valid_q[raddr_a_q] ? rdata_a_q : '0;
  assign rdata_b_o = valid_q[raddr_b_q] ? rdata_b_q : '0;

endmodule

`default_nettype wire

FILE: rtl/frame_chunk_reassembly_ring.sv
// ----------------------------------------------------------------------------
// frame_chunk_reassembly_ring
// Tracks reassembly of numbered frames from chunks in a ring of slots.
// ----------------------------------------------------------------------------
// The slot memory is read at the edge that accepts a transaction; in ST_EXEC
// the result is computed, written back and registered once the output is
// free, so one item is in work at a time. A new transaction may be accepted
// while the previous result still waits in the output register. A jump clears
// all slots at once through per-slot valid bits, so there is no clearing pass
// after reset or on a jump.
`default_nettype none
`include "assert_macros.svh"

module frame_chunk_reassembly_ring (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              op_i,
  input  wire  [fcrr_pkg::FNUM_W-1:0]      frame_num_i,
  input  wire  [fcrr_pkg::SIZE_W-1:0]      frame_size_i,
  input  wire  [fcrr_pkg::CLEN_W-1:0]      chunk_len_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             accepted_o,
  output logic                             jumped_o,
  output logic                             front_complete_o,
  output logic [fcrr_pkg::SIZE_W-1:0]      front_size_o,
  output logic                             corrupt_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [fcrr_pkg::PADDR_W-1:0]     paddr,
  input  wire  [fcrr_pkg::PDATA_W-1:0]     pwdata,
  output logic [fcrr_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                           state_q;
  logic                             op_q;
  logic [fcrr_pkg::FNUM_W-1:0]      fnum_q;
  logic [fcrr_pkg::SIZE_W-1:0]      fsize_q;
  logic [fcrr_pkg::CLEN_W-1:0]      clen_q;
  logic [fcrr_pkg::FNUM_W-1:0]      exp_q;
  logic [fcrr_pkg::FNUM_W-1:0]      exp_d;
  logic signed [fcrr_pkg::CNT_W-1:0] hold_q;
  logic signed [fcrr_pkg::CNT_W-1:0] hold_d;
  logic [fcrr_pkg::HOLD_W-1:0]      holdoff_cfg_q;
  logic                             out_valid_q;
  logic                             accepted_q, accepted_d;
  logic                             jumped_q, jumped_d;
  logic                             complete_q, complete_d;
  logic [fcrr_pkg::SIZE_W-1:0]      fsize_out_q, fsize_out_d;
  logic                             corrupt_q, corrupt_d;

  logic                             in_acc;
  logic                             finish;
  logic                             cfg_wr;
  logic                             behind;
  logic                             jump;
  logic [fcrr_pkg::IDX_W-1:0]       sidx;
  logic [fcrr_pkg::IDX_W-1:0]       eidx;
  logic [fcrr_pkg::IDX_W-1:0]       fidx;
  logic [fcrr_pkg::SIZE_W:0]        sum;
  logic                             incomplete;
  fcrr_pkg::slot_t                  slot_a;
  fcrr_pkg::slot_t                  slot_b;
  fcrr_pkg::slot_t                  cur_s;
  fcrr_pkg::slot_t                  new_s;
  fcrr_pkg::slot_t                  front_s;
  fcrr_pkg::wr_req_t                wr;
  logic                             pop_shown;
  logic                             add_flags;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign finish     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[fcrr_pkg::PADDR_W-1:2] == fcrr_pkg::REG_CORRUPT_HOLDOFF) ?
                      fcrr_pkg::PDATA_W'(holdoff_cfg_q) : '0;

  fcrr_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_acc),
    .raddr_a_i ((op_i == fcrr_pkg::OP_POP) ? exp_q[fcrr_pkg::IDX_W-1:0] :
                frame_num_i[fcrr_pkg::IDX_W-1:0]),
    .raddr_b_i (exp_q[fcrr_pkg::IDX_W-1:0]),
    .wr_i      (wr),
    .rdata_a_o (slot_a),
    .rdata_b_o (slot_b)
  );

  always_comb begin
    sidx       = fnum_q[fcrr_pkg::IDX_W-1:0];
    eidx       = exp_q[fcrr_pkg::IDX_W-1:0];
    behind     = fnum_q < exp_q;
    jump       = {1'b0, fnum_q} >= ({1'b0, exp_q} + (fcrr_pkg::FNUM_W+1)'(fcrr_pkg::SLOTS));
    fidx       = jump ? sidx : eidx;
    cur_s      = jump ? '0 : slot_a;
    sum        = {1'b0, cur_s.rcv} + (fcrr_pkg::SIZE_W+1)'(clen_q);
    new_s.size = fsize_q;
    new_s.rcv  = sum[fcrr_pkg::SIZE_W] ? '1 : sum[fcrr_pkg::SIZE_W-1:0];
    front_s    = (fidx == sidx) ? new_s : slot_b;
    incomplete = (slot_a.rcv != slot_a.size) || (slot_a.size == '0);

    exp_d       = exp_q;
    hold_d      = hold_q;
    accepted_d  = 1'b0;
    jumped_d    = 1'b0;
    complete_d  = 1'b0;
    fsize_out_d = '0;
    corrupt_d   = 1'b0;
    wr          = '0;
    wr.waddr    = sidx;
    wr.wdata    = new_s;
    wr.inval_addr = eidx;

    if (op_q == fcrr_pkg::OP_ADD) begin
      if (!behind) begin
        accepted_d   = 1'b1;
        jumped_d     = jump;
        complete_d   = (front_s.rcv == front_s.size) && (front_s.size != '0);
        wr.we        = finish;
        wr.clear_all = finish && jump;
        if (jump) begin
          exp_d = fnum_q;
        end
      end
    end else begin
      fsize_out_d   = slot_a.size;
      wr.invalidate = finish;
      exp_d         = exp_q + 1'b1;
      if (incomplete) begin
        hold_d = $signed({1'b0, holdoff_cfg_q});
      end else if (!hold_q[fcrr_pkg::CNT_W-1]) begin
        corrupt_d = (hold_q == '0);
        hold_d    = hold_q - fcrr_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= fcrr_pkg::OP_ADD;
      fnum_q        <= '0;
      fsize_q       <= '0;
      clen_q        <= '0;
      exp_q         <= '0;
      hold_q        <= '1;
      holdoff_cfg_q <= fcrr_pkg::HOLDOFF_RESET;
      out_valid_q   <= 1'b0;
      accepted_q    <= 1'b0;
      jumped_q      <= 1'b0;
      complete_q    <= 1'b0;
      fsize_out_q   <= '0;
      corrupt_q     <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[fcrr_pkg::PADDR_W-1:2] == fcrr_pkg::REG_CORRUPT_HOLDOFF)) begin
        holdoff_cfg_q <= pwdata[fcrr_pkg::HOLD_W-1:0];
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= op_i;
            fnum_q  <= frame_num_i;
            fsize_q <= frame_size_i;
            clen_q  <= chunk_len_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (finish) begin
            exp_q       <= exp_d;
            hold_q      <= hold_d;
            accepted_q  <= accepted_d;
            jumped_q    <= jumped_d;
            complete_q  <= complete_d;
            fsize_out_q <= fsize_out_d;
            corrupt_q   <= corrupt_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign jumped_o         = jumped_q;
  assign front_complete_o = complete_q;
  assign front_size_o     = fsize_out_q;
  assign corrupt_o        = corrupt_q;

  assign pop_shown = out_valid_o && (corrupt_o || (front_size_o != '0));
  assign add_flags = accepted_o || jumped_o || front_complete_o;

  `FCRR_ASSERT(a_one_in_flight, in_acc |=> in_stall_o, "second transaction accepted while busy")
  `FCRR_ASSERT(a_jump_is_accepted, (out_valid_o && jumped_o) |-> accepted_o, "jump on rejected add")
  `FCRR_ASSERT(a_pop_fields, pop_shown |-> !add_flags, "add and pop fields mixed")
  `FCRR_ASSERT_NEVER(a_hold_range, hold_q[fcrr_pkg::CNT_W-1] && (hold_q != '1), "holdoff below idle")

endmodule

`default_nettype wire
